>>> hdl/atkin_pkg.sv
// ----------------------------------------------------------------------------
// atkin_pkg
// Shared types, constants and the mod-60 wheel classifier for the sieve.
// ----------------------------------------------------------------------------
package atkin_pkg;

    localparam int MAX_N      = 1048576;
    localparam int AW         = $clog2(MAX_N);
    localparam int LW         = AW + 1;
    localparam int VW         = AW + 2;
    localparam int XW         = 12;
    localparam int TDATA_IN_W = 24;
    localparam int TDATA_OUT_W = 24;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_A    = 2'd1;
    localparam logic [1:0] CLS_B    = 2'd2;
    localparam logic [1:0] CLS_C    = 2'd3;

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_Q_OUT,
        ST_CLR,
        ST_P1_X,
        ST_P1_Y,
        ST_P1_W,
        ST_P2_X,
        ST_P2_Y,
        ST_P2_W,
        ST_P3_X,
        ST_P3_Y,
        ST_P3_W,
        ST_SQ_N,
        ST_SQ_R,
        ST_SQ_C,
        ST_CNT,
        ST_CNT_END,
        ST_FIN,
        ST_B_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH_Q,
        OP_Q_OUT,
        OP_CLR_INIT,
        OP_CLR,
        OP_P1_INIT,
        OP_P1_XNEXT,
        OP_P1_YINIT,
        OP_P2_INIT,
        OP_P2_XNEXT,
        OP_P2_YINIT,
        OP_P3_INIT,
        OP_P3_XNEXT,
        OP_P3_YINIT,
        OP_YSTEP_UP,
        OP_YSTEP_DN,
        OP_READ_N,
        OP_TOG_UP,
        OP_TOG_DN,
        OP_SQ_INIT,
        OP_SQ_XNEXT,
        OP_READ_X,
        OP_SQ_CINIT,
        OP_SQ_CLR,
        OP_CNT_INIT,
        OP_CNT_RD,
        OP_FIN,
        OP_B_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       m_ge_lim;
        logic       n_ge_lim;
        logic       t_ge_lim;
        logic       a_ge_lim;
        logic       y_zero;
        logic [1:0] n_cls;
        logic [1:0] x_cls;
        logic       rd_bit;
        logic       out_free;
    } dp_stat_t;

    // residue class of v mod 60: nibble sum gives mod 15, CRT with mod 4
    function automatic logic [1:0] wheel_class(input logic [AW-1:0] v);
        logic [6:0] s;
        logic [4:0] s2;
        logic [3:0] m15;
        logic [1:0] m4;
        logic [1:0] k;
        logic [5:0] r;
        logic [1:0] c;
        s   = 7'(v[3:0]) + 7'(v[7:4]) + 7'(v[11:8]) + 7'(v[15:12]) + 7'(v[19:16]);
        s2  = 5'(s[3:0]) + 5'(s[6:4]);
        m15 = (s2 >= 5'd15) ? 4'(s2 - 5'd15) : s2[3:0];
        m4  = v[1:0];
        k   = 2'(m15[1:0] - m4);
        r   = 6'(m15) + 6'({k, 4'b0} - {4'b0, k});
        case (r) inside
            6'd1, 6'd13, 6'd17, 6'd29, 6'd37, 6'd41, 6'd49, 6'd53: c = CLS_A;
            6'd7, 6'd19, 6'd31, 6'd43:                             c = CLS_B;
            6'd11, 6'd23, 6'd47, 6'd59:                            c = CLS_C;
            default:                                               c = CLS_NONE;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/atkin_ctrl.sv
// ----------------------------------------------------------------------------
// atkin_ctrl
// Sequencer for queries, and for builds: clear, the three toggle passes, square removal and count.
// ----------------------------------------------------------------------------
module atkin_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    input  atkin_pkg::dp_stat_t st,
    output atkin_pkg::dp_cmd_t  cmd
);
    import atkin_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_cmd == CMD_QUERY) ? ST_Q_OUT : ST_CLR;
                end
            end
            ST_Q_OUT:   if (st.out_free) state_next = ST_IDLE;
            ST_CLR:     if (st.a_ge_lim) state_next = ST_P1_X;
            ST_P1_X:    state_next = st.m_ge_lim ? ST_P2_X : ST_P1_Y;
            ST_P1_Y:
            begin
                if (st.n_ge_lim)            state_next = ST_P1_X;
                else if (st.n_cls == CLS_A) state_next = ST_P1_W;
            end
            ST_P1_W:    state_next = ST_P1_Y;
            ST_P2_X:    state_next = st.m_ge_lim ? ST_P3_X : ST_P2_Y;
            ST_P2_Y:
            begin
                if (st.n_ge_lim)            state_next = ST_P2_X;
                else if (st.n_cls == CLS_B) state_next = ST_P2_W;
            end
            ST_P2_W:    state_next = ST_P2_Y;
            ST_P3_X:    state_next = st.t_ge_lim ? ST_SQ_N : ST_P3_Y;
            ST_P3_Y:
            begin
                if (st.y_zero || st.n_ge_lim) state_next = ST_P3_X;
                else if (st.n_cls == CLS_C)   state_next = ST_P3_W;
            end
            ST_P3_W:    state_next = ST_P3_Y;
            ST_SQ_N:
            begin
                if (st.m_ge_lim)                  state_next = ST_CNT;
                else if (st.x_cls != CLS_NONE)    state_next = ST_SQ_R;
            end
            ST_SQ_R:    state_next = st.rd_bit ? ST_SQ_C : ST_SQ_N;
            ST_SQ_C:    if (st.a_ge_lim) state_next = ST_SQ_N;
            ST_CNT:     if (st.a_ge_lim) state_next = ST_CNT_END;
            ST_CNT_END: state_next = ST_FIN;
            ST_FIN:     state_next = ST_B_OUT;
            ST_B_OUT:   if (st.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = (in_cmd == CMD_QUERY) ? OP_LATCH_Q : OP_CLR_INIT;
                end
            end
            ST_Q_OUT:   if (st.out_free) cmd.op = OP_Q_OUT;
            ST_CLR:     cmd.op = st.a_ge_lim ? OP_P1_INIT : OP_CLR;
            ST_P1_X:    cmd.op = st.m_ge_lim ? OP_P2_INIT : OP_P1_YINIT;
            ST_P1_Y:
            begin
                if (st.n_ge_lim)            cmd.op = OP_P1_XNEXT;
                else if (st.n_cls == CLS_A) cmd.op = OP_READ_N;
                else                        cmd.op = OP_YSTEP_UP;
            end
            ST_P1_W:    cmd.op = OP_TOG_UP;
            ST_P2_X:    cmd.op = st.m_ge_lim ? OP_P3_INIT : OP_P2_YINIT;
            ST_P2_Y:
            begin
                if (st.n_ge_lim)            cmd.op = OP_P2_XNEXT;
                else if (st.n_cls == CLS_B) cmd.op = OP_READ_N;
                else                        cmd.op = OP_YSTEP_UP;
            end
            ST_P2_W:    cmd.op = OP_TOG_UP;
            ST_P3_X:    cmd.op = st.t_ge_lim ? OP_SQ_INIT : OP_P3_YINIT;
            ST_P3_Y:
            begin
                if (st.y_zero || st.n_ge_lim) cmd.op = OP_P3_XNEXT;
                else if (st.n_cls == CLS_C)   cmd.op = OP_READ_N;
                else                          cmd.op = OP_YSTEP_DN;
            end
            ST_P3_W:    cmd.op = OP_TOG_DN;
            ST_SQ_N:
            begin
                if (st.m_ge_lim)               cmd.op = OP_CNT_INIT;
                else if (st.x_cls != CLS_NONE) cmd.op = OP_READ_X;
                else                           cmd.op = OP_SQ_XNEXT;
            end
            ST_SQ_R:    cmd.op = st.rd_bit ? OP_SQ_CINIT : OP_SQ_XNEXT;
            ST_SQ_C:    cmd.op = st.a_ge_lim ? OP_SQ_XNEXT : OP_SQ_CLR;
            ST_CNT:     cmd.op = st.a_ge_lim ? OP_NONE : OP_CNT_RD;
            ST_CNT_END: cmd.op = OP_NONE;
            ST_FIN:     cmd.op = OP_FIN;
            ST_B_OUT:   if (st.out_free) cmd.op = OP_B_OUT;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> hdl/atkin_dp.sv
// ----------------------------------------------------------------------------
// atkin_dp
// Loop registers, sieve bit memory, prime counter and result register.
// ----------------------------------------------------------------------------
module atkin_dp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [atkin_pkg::LW-1:0] cfg_wdata,
    input  logic [atkin_pkg::AW-1:0] in_cand,
    input  atkin_pkg::dp_cmd_t     cmd,
    output atkin_pkg::dp_stat_t    st,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   out_is_prime,
    output logic                   out_in_range,
    output logic [atkin_pkg::LW-1:0] out_count
);
    import atkin_pkg::*;

    logic           mem_q [0:MAX_N-1];
    logic           rd_bit_reg;

    logic [LW-1:0]  limit_reg;
    logic [LW-1:0]  count_reg;
    logic [LW-1:0]  built_lim_reg;
    logic           built_reg;
    logic           cnt_vld_reg;
    logic           out_valid_reg;
    logic [LW-1:0]  cnt_reg;
    logic [LW-1:0]  cnt_next;

    logic [XW-1:0]  x_reg;
    logic [XW-1:0]  x_next;
    logic [XW-1:0]  y_reg;
    logic [XW-1:0]  y_next;
    logic [VW-1:0]  m_reg;
    logic [VW-1:0]  m_next;
    logic [VW-1:0]  d_reg;
    logic [VW-1:0]  d_next;
    logic [VW-1:0]  ysq_reg;
    logic [VW-1:0]  ysq_next;
    logic [VW-1:0]  n_reg;
    logic [VW-1:0]  n_next;
    logic [VW-1:0]  a_reg;
    logic [VW-1:0]  a_next;
    logic [AW-1:0]  cand_reg;
    logic           is_prime_reg;
    logic           in_range_reg;
    logic [LW-1:0]  ocount_reg;

    logic [LW-1:0]  lim;
    logic [VW-1:0]  lim_v;
    logic [VW-1:0]  xw;
    logic [VW-1:0]  yw;
    logic [VW-1:0]  ysq_up;
    logic [VW-1:0]  ysq_dn;
    logic [LW-1:0]  extra;
    logic           q_inr;
    logic           q_prime;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic           mem_wbit;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;

    assign lim    = (limit_reg > LW'(MAX_N)) ? LW'(MAX_N) : limit_reg;
    assign lim_v  = VW'(lim);
    assign xw     = VW'(x_reg);
    assign yw     = VW'(y_reg);
    assign ysq_up = ysq_reg + (yw << 2) + VW'(4);
    assign ysq_dn = ysq_reg - (yw << 2) + VW'(4);

    assign st.m_ge_lim = (m_reg >= lim_v);
    assign st.n_ge_lim = (n_reg >= lim_v);
    assign st.t_ge_lim = ((m_reg - d_reg) >= lim_v);
    assign st.a_ge_lim = (a_reg >= lim_v);
    assign st.y_zero   = (y_reg == '0);
    assign st.n_cls    = wheel_class(n_reg[AW-1:0]);
    assign st.x_cls    = wheel_class(AW'(x_reg));
    assign st.rd_bit   = rd_bit_reg;
    assign st.out_free = !out_valid_reg || out_ready;

    assign extra = LW'(lim > LW'(2)) + LW'(lim > LW'(3)) + LW'(lim > LW'(5));

    assign q_inr   = (LW'(cand_reg) < lim);
    assign q_prime = q_inr && built_reg &&
                     ((cand_reg == AW'(2)) || (cand_reg == AW'(3)) || (cand_reg == AW'(5)) ||
                      ((LW'(cand_reg) < built_lim_reg) && rd_bit_reg));

    assign cnt_next = cnt_vld_reg ? cnt_reg + LW'(rd_bit_reg) : cnt_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = a_reg[AW-1:0];
        mem_wbit  = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = n_reg[AW-1:0];
        case (cmd.op)
            OP_LATCH_Q:
            begin
                mem_re    = 1'b1;
                mem_raddr = in_cand;
            end
            OP_READ_N:  mem_re = 1'b1;
            OP_READ_X:
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(x_reg);
            end
            OP_CNT_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = a_reg[AW-1:0];
            end
            OP_CLR, OP_SQ_CLR: mem_we = 1'b1;
            OP_TOG_UP, OP_TOG_DN:
            begin
                mem_we    = 1'b1;
                mem_waddr = n_reg[AW-1:0];
                mem_wbit  = !rd_bit_reg;
            end
            default:    mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_q[mem_waddr] <= mem_wbit;
        end
        if (mem_re)
        begin
            rd_bit_reg <= mem_q[mem_raddr];
        end
    end

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        m_next   = m_reg;
        d_next   = d_reg;
        ysq_next = ysq_reg;
        n_next   = n_reg;
        a_next   = a_reg;
        case (cmd.op)
            OP_CLR_INIT, OP_CNT_INIT: a_next = '0;
            OP_CLR, OP_CNT_RD:        a_next = a_reg + VW'(1);
            OP_P1_INIT:
            begin
                x_next = XW'(1);
                m_next = VW'(4);
            end
            OP_P1_XNEXT:
            begin
                x_next = x_reg + XW'(1);
                m_next = m_reg + (xw << 3) + VW'(4);
            end
            OP_P1_YINIT:
            begin
                y_next   = XW'(1);
                ysq_next = VW'(1);
                n_next   = m_reg + VW'(1);
            end
            OP_P2_INIT:
            begin
                x_next = XW'(1);
                m_next = VW'(3);
            end
            OP_P2_XNEXT:
            begin
                x_next = x_reg + XW'(2);
                m_next = m_reg + (xw << 3) + (xw << 2) + VW'(12);
            end
            OP_P2_YINIT:
            begin
                y_next   = XW'(2);
                ysq_next = VW'(4);
                n_next   = m_reg + VW'(4);
            end
            OP_P3_INIT:
            begin
                x_next = XW'(2);
                m_next = VW'(12);
                d_next = VW'(1);
            end
            OP_P3_XNEXT:
            begin
                x_next = x_reg + XW'(1);
                m_next = m_reg + (xw << 2) + (xw << 1) + VW'(3);
                d_next = d_reg + (xw << 1) - VW'(1);
            end
            OP_P3_YINIT:
            begin
                y_next   = x_reg - XW'(1);
                ysq_next = d_reg;
                n_next   = m_reg - d_reg;
            end
            OP_YSTEP_UP, OP_TOG_UP:
            begin
                y_next   = y_reg + XW'(2);
                ysq_next = ysq_up;
                n_next   = m_reg + ysq_up;
            end
            OP_YSTEP_DN, OP_TOG_DN:
            begin
                if (y_reg >= XW'(2))
                begin
                    y_next   = y_reg - XW'(2);
                    ysq_next = ysq_dn;
                    n_next   = m_reg - ysq_dn;
                end
                else
                begin
                    y_next = '0;
                end
            end
            OP_SQ_INIT:
            begin
                x_next = XW'(7);
                m_next = VW'(49);
            end
            OP_SQ_XNEXT:
            begin
                x_next = x_reg + XW'(1);
                m_next = m_reg + (xw << 1) + VW'(1);
            end
            OP_SQ_CINIT: a_next = m_reg;
            OP_SQ_CLR:   a_next = a_reg + m_reg;
            default:     a_next = a_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
        d_reg   <= d_next;
        ysq_reg <= ysq_next;
        n_reg   <= n_next;
        a_reg   <= a_next;
        if (cmd.op == OP_LATCH_Q)
        begin
            cand_reg <= in_cand;
        end
        if (cmd.op == OP_CNT_INIT)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
        if (cmd.op == OP_Q_OUT)
        begin
            is_prime_reg <= q_prime;
            in_range_reg <= q_inr;
            ocount_reg   <= count_reg;
        end
        else if (cmd.op == OP_B_OUT)
        begin
            is_prime_reg <= 1'b0;
            in_range_reg <= 1'b0;
            ocount_reg   <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LW'(MAX_N);
            count_reg     <= '0;
            built_reg     <= 1'b0;
            built_lim_reg <= '0;
            cnt_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            cnt_vld_reg <= (cmd.op == OP_CNT_RD);
            if (cmd.op == OP_FIN)
            begin
                count_reg     <= cnt_reg + extra;
                built_reg     <= 1'b1;
                built_lim_reg <= lim;
            end
            if (cmd.op == OP_Q_OUT || cmd.op == OP_B_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_is_prime = is_prime_reg;
    assign out_in_range = in_range_reg;
    assign out_count    = ocount_reg;

endmodule

>>> hdl/prime_sieve_atkin_top.sv
// ----------------------------------------------------------------------------
// prime_sieve_atkin_top
// Sieve of Atkin over a 1M-bit table with build and query commands.
// ----------------------------------------------------------------------------
// Query: the accept latches the candidate and its table bit; the result word
//   is registered once the output is free, and only then is a new word taken.
// Build: clear below the limit, three toggle passes, square removal, count;
//   each step reads or writes the bit table at most once per cycle.
// Reset: limit goes to 1048576, count and built flag clear; the bit table
//   is not cleared at reset (every build clears it below the limit).
// ----------------------------------------------------------------------------
module prime_sieve_atkin_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata,     // sieve_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [atkin_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // cmd[0], candidate[20:1], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [atkin_pkg::TDATA_OUT_W-1:0] m_axis_tdata
    // m_axis_tdata: is_prime[0], in_range[1], prime_count[22:2], pad
);
    import atkin_pkg::*;

    dp_cmd_t       cmd;
    dp_stat_t      st;
    logic          is_prime;
    logic          in_range;
    logic [LW-1:0] prime_count;

    atkin_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tdata[0]),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    atkin_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_cand      (s_axis_tdata[20:1]),
        .cmd          (cmd),
        .st           (st),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_is_prime (is_prime),
        .out_in_range (in_range),
        .out_count    (prime_count)
    );

    assign m_axis_tdata = {1'b0, prime_count, in_range, is_prime};

endmodule

>>> tb/prime_sieve_atkin_checker.sv
// ----------------------------------------------------------------------------
// prime_sieve_atkin_checker
// Watches the config port and both streams, keeps its own sieve table and
// compares every result word, field by field, with the predicted one.
// ----------------------------------------------------------------------------
module prime_sieve_atkin_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    output int          fail_count,
    output int          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import atkin_pkg::*;

    typedef struct packed {
        logic [20:0] prime_count;
        logic        in_range;
        logic        is_prime;
    } answer_t;

    bit          table_bits [MAX_N];
    int          dirty_top;
    logic [20:0] limit_reg;
    logic [20:0] count_val;
    bit          built;
    answer_t     expected_words [$];

    function automatic int wheel_kind(input int v);
        case (v % 60)
            1, 13, 17, 29, 37, 41, 49, 53: return 1;
            7, 19, 31, 43:                 return 2;
            11, 23, 47, 59:                return 3;
            default:                       return 0;
        endcase
    endfunction

    function automatic int eff_lim();
        return (limit_reg > MAX_N) ? MAX_N : int'(limit_reg);
    endfunction

    task automatic sieve_rebuild();
        int lim;
        int x;
        int y;
        int m;
        int n;
        int c;
        int cnt;
        lim = eff_lim();
        for (n = 0; n < dirty_top; n++)
            table_bits[n] = 0;
        dirty_top = lim;
        for (x = 1; 4 * x * x < lim; x++)
            for (y = 1; 4 * x * x + y * y < lim; y += 2)
            begin
                n = 4 * x * x + y * y;
                if (wheel_kind(n) == 1) table_bits[n] ^= 1'b1;
            end
        for (x = 1; 3 * x * x < lim; x += 2)
            for (y = 2; 3 * x * x + y * y < lim; y += 2)
            begin
                n = 3 * x * x + y * y;
                if (wheel_kind(n) == 2) table_bits[n] ^= 1'b1;
            end
        for (x = 2; 3 * x * x - (x - 1) * (x - 1) < lim; x++)
        begin
            m = 3 * x * x;
            for (y = x - 1; y > 0; y = (y >= 2) ? y - 2 : 0)
            begin
                n = m - y * y;
                if (n >= lim) break;
                if (wheel_kind(n) == 3) table_bits[n] ^= 1'b1;
            end
        end
        for (n = 7; n * n < lim; n++)
        begin
            if (wheel_kind(n) == 0 || !table_bits[n]) continue;
            for (c = n * n; c < lim; c += n * n)
                table_bits[c] = 0;
        end
        cnt = 0;
        for (n = 0; n < lim; n++)
            if (table_bits[n]) cnt++;
        if (lim > 2) cnt++;
        if (lim > 3) cnt++;
        if (lim > 5) cnt++;
        count_val = 21'(cnt);
        built     = 1;
    endtask

    function automatic answer_t answer_query(input logic [19:0] cand);
        answer_t a;
        a.prime_count = count_val;
        a.in_range    = int'(cand) < eff_lim();
        a.is_prime    = 0;
        if (a.in_range && built)
            a.is_prime = (cand == 2 || cand == 3 || cand == 5) ? 1'b1 : table_bits[cand];
        return a;
    endfunction

    assign pending = expected_words.size();

    initial
    begin
        fail_count = 0;
        dirty_top  = MAX_N;
        limit_reg  = 21'd1048576;
        count_val  = 0;
        built      = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        answer_t a;
        answer_t got;
        if (!rst_n)
        begin
            limit_reg = 21'd1048576;
            count_val = 0;
            built     = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_we) limit_reg = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[22:0];
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                end
                else
                begin
                    a = expected_words.pop_front();
                    if (got !== a)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch prime %b/%b range %b/%b count %0d/%0d",
                                     $time, a.is_prime, got.is_prime, a.in_range,
                                     got.in_range, a.prime_count, got.prime_count);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tdata[0] == CMD_BUILD)
                begin
                    sieve_rebuild();
                    a = '0;
                    a.prime_count = count_val;
                end
                else
                    a = answer_query(s_axis_tdata[20:1]);
                expected_words.push_back(a);
            end
        end
    end

endmodule

>>> tb/prime_sieve_atkin_top_tb.sv
// ----------------------------------------------------------------------------
// prime_sieve_atkin_top_tb
// Drives limit settings, build and query words with random gaps and stalls,
// including a long output hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module prime_sieve_atkin_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import atkin_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [20:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          send_idle;
    int          recv_idle;
    int          hold_len;
    int          cur_lim;

    prime_sieve_atkin_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    prime_sieve_atkin_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stalls, or a long counted hold-off on request
    initial
    begin
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                m_axis_tready <= 0;
                hold_len--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_word(input logic cmd, input logic [19:0] cand);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {3'b0, cand, cmd};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic set_limit(input logic [20:0] v);
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we  <= 0;
        cur_lim = (v > MAX_N) ? MAX_N : int'(v);
    endtask

    function automatic logic [19:0] pick_cand();
        case ($urandom_range(3))
            0:       return 20'($urandom);
            1:       return 20'($urandom_range(cur_lim + 2));
            2:       return 20'(cur_lim + int'($urandom_range(4)) - 2);
            default: return 20'($urandom_range(60));
        endcase
    endfunction

    initial
    begin
        int ph;
        int k;
        int lim;
        rst_n         = 0;
        cfg_we        = 0;
        cfg_wdata     = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        hold_len      = 0;
        send_idle     = 15;
        recv_idle     = 56;
        cur_lim       = MAX_N;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // queries before any build
        send_word(CMD_QUERY, 20'd2);
        send_word(CMD_QUERY, 20'hFFFFF);
        send_word(CMD_QUERY, 20'd0);
        set_limit(21'd8);
        send_word(CMD_BUILD, 20'hFFFFF);
        for (k = 0; k < 9; k++) send_word(CMD_QUERY, 20'(k));
        set_limit(21'd4);
        send_word(CMD_BUILD, 20'd0);
        send_word(CMD_QUERY, 20'd3);
        send_word(CMD_QUERY, 20'd5);
        set_limit(21'd0);
        send_word(CMD_BUILD, 20'd0);
        send_word(CMD_QUERY, 20'd0);
        set_limit(21'd1000);
        send_word(CMD_BUILD, 20'd0);
        send_word(CMD_QUERY, 20'd997);
        send_word(CMD_QUERY, 20'd999);
        send_word(CMD_QUERY, 20'd1000);
        set_limit(21'd1048576);
        send_word(CMD_QUERY, 20'd1009);
        send_word(CMD_QUERY, 20'd997);
        set_limit(21'h1FFFFF);
        send_word(CMD_QUERY, 20'hFFFFF);
        send_word(CMD_QUERY, 20'd49);

        for (ph = 0; ph < 9; ph++)
        begin
            send_idle = (ph < 3) ? 15 : (ph < 6) ? 56 : 0;
            recv_idle = (ph < 3) ? 56 : (ph < 6) ? 15 : 0;
            if (ph == 4)      lim = 60000;
            else if (ph == 7) lim = 1048576;
            else              lim = $urandom_range(3000, 8);
            set_limit(21'(lim));
            if (ph != 7) send_word(CMD_BUILD, 20'($urandom));
            if (ph == 2) hold_len = 12000;
            for (k = 0; k < 8; k++)
                if (ph != 7 && $urandom_range(19) == 0)
                    send_word(CMD_BUILD, 20'($urandom));
                else
                    send_word(CMD_QUERY, pick_cand());
        end
        s_axis_tvalid <= 0;

        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
